[hw/rtl/running_median_pop_defines.svh]
// Assertion helpers shared by the RTL files.
`ifndef RUNNING_MEDIAN_POP_DEFINES_SVH
`define RUNNING_MEDIAN_POP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define RMP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("running_median_pop: assertion failed");

// Check a consequence in the cycle after its cause.
`define RMP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("running_median_pop: assertion failed");

`endif

[hw/rtl/rmp_pkg.sv]
package rmp_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int STATUS_W         = 2;
    localparam int GROUP_SIZE       = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_POP    = 1'b1
    } t_mode;

    typedef struct packed {
        logic                      ins_en;
        logic                      pop_en;
        logic signed [VALUE_W-1:0] value;
    } t_cell_cmd;

endpackage

[hw/rtl/running_median_pop.sv]
// running_median_pop: sorted store of signed 32-bit values with lower-median pop.
// Input channel (s): tdata[31:0] = value, tuser[0] = mode (0 insert, 1 pop).
// Output channel (m): tdata[31:0] = median, tuser[1:0] = status
//   (0 median returned, 1 pop on empty, 2 insert dropped because full).
// A successful insert gives no output beat; every pop and every dropped
// insert gives exactly one, in input order.
// The store is a chain of CAPACITY compare-and-shift cells: each cell holds
// one sorted entry and in the cycle of acceptance takes its own value, its
// lower neighbor's, its upper neighbor's or the new value.
// Throughput: one input beat per cycle, except while o_s_tready is low.
// The median is gathered from the cells through a two-level registered OR
// tree, GROUP_SIZE cells per group in the first level, to the output beat.
// Reset (synchronous, i_rst_n low) empties the store and drops any pending
// output beat; no clearing pass is needed.
// When the receiver stalls, the output beat holds, the middle stage fills,
// and then o_s_tready falls until the output beat is taken.
`include "running_median_pop_defines.svh"

module running_median_pop
    import rmp_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [VALUE_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic                i_s_tuser,   // [0] mode
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [VALUE_W-1:0]  o_m_tdata,   // [31:0] median
    output logic [STATUS_W-1:0] o_m_tuser    // [1:0] status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int NGRP = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] w_pos;

    logic          w_accept;
    logic          w_pop;
    logic          w_full;
    logic          w_empty;
    t_cell_cmd     w_cmd;

    logic                      w_b   [0:CAPACITY];
    logic signed [VALUE_W-1:0] w_val [0:CAPACITY];
    logic        [VALUE_W-1:0] w_med [0:NGRP*GROUP_SIZE-1];
    logic        [VALUE_W-1:0] w_grp [0:NGRP-1];

    logic               r_s1_valid;
    logic               n_s1_valid;
    t_status            r_s1_status;
    t_status            n_s1_status;
    logic [VALUE_W-1:0] r_s1_grp [0:NGRP-1];

    logic               r_out_valid;
    logic               n_out_valid;
    t_status            r_out_status;
    t_status            n_out_status;
    logic [VALUE_W-1:0] r_out_med;
    logic [VALUE_W-1:0] n_out_med;
    logic [VALUE_W-1:0] w_tree;
    logic               w_s1_adv;

    assign w_pos    = (r_count - CW'(1)) >> 1;
    assign w_full   = r_count == CW'(CAPACITY);
    assign w_empty  = r_count == '0;
    assign w_pop    = t_mode'(i_s_tuser) == MODE_POP;
    assign w_s1_adv = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || w_s1_adv;
    assign w_accept = i_s_tvalid && o_s_tready;

    assign w_cmd.ins_en = w_accept && !w_pop && !w_full;
    assign w_cmd.pop_en = w_accept && w_pop && !w_empty;
    assign w_cmd.value  = $signed(i_s_tdata);

    assign w_b[0]   = 1'b0;
    assign w_val[0] = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic signed [VALUE_W-1:0] w_next;
        if (gi < CAPACITY - 1) begin : g_mid
            assign w_next = w_val[gi+2];
        end else begin : g_last
            assign w_next = w_val[gi+1];
        end
        rmp_cell #(
            .IDX (gi),
            .CW  (CW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (w_cmd),
            .i_count    (r_count),
            .i_pos      (w_pos),
            .i_prev_b   (w_b[gi]),
            .i_prev_val (w_val[gi]),
            .i_next_val (w_next),
            .o_b        (w_b[gi+1]),
            .o_val      (w_val[gi+1]),
            .o_med      (w_med[gi])
        );
    end

    for (genvar gp = CAPACITY; gp < NGRP*GROUP_SIZE; gp++) begin : g_pad
        assign w_med[gp] = '0;
    end

    for (genvar gg = 0; gg < NGRP; gg++) begin : g_grp
        always_comb begin
            w_grp[gg] = '0;
            for (int j = 0; j < GROUP_SIZE; j++) begin
                w_grp[gg] = w_grp[gg] | w_med[gg*GROUP_SIZE + j];
            end
        end
    end

    always_comb begin
        w_tree = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_tree = w_tree | r_s1_grp[g];
        end
    end

    always_comb begin
        n_count = r_count;
        if (w_cmd.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.pop_en) begin
            n_count = r_count - CW'(1);
        end
    end

    always_comb begin
        n_s1_valid  = r_s1_valid;
        n_s1_status = r_s1_status;
        if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end
        if (w_accept && (w_pop || w_full)) begin
            n_s1_valid = 1'b1;
            if (!w_pop) begin
                n_s1_status = ST_FULL;
            end else if (w_empty) begin
                n_s1_status = ST_EMPTY;
            end else begin
                n_s1_status = ST_OK;
            end
        end
    end

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_med    = r_out_med;
        if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
        if (w_s1_adv && r_s1_valid) begin
            n_out_valid  = 1'b1;
            n_out_status = r_s1_status;
            n_out_med    = (r_s1_status == ST_OK) ? w_tree : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_status  <= n_s1_status;
        r_out_status <= n_out_status;
        r_out_med    <= n_out_med;
        if (w_accept) begin
            for (int g = 0; g < NGRP; g++) begin
                r_s1_grp[g] <= w_grp[g];
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_med;
    assign o_m_tuser  = r_out_status;

    `RMP_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(CAPACITY))
    `RMP_ASSERT_NEXT(a_ins_grows, i_clk, i_rst_n, w_cmd.ins_en, r_count == $past(r_count) + CW'(1))
    `RMP_ASSERT_NEXT(a_pop_shrinks, i_clk, i_rst_n, w_cmd.pop_en, r_count == $past(r_count) - CW'(1))
    `RMP_ASSERT_NEXT(a_empty_status, i_clk, i_rst_n, w_accept && w_pop && w_empty, r_s1_valid && r_s1_status == ST_EMPTY)
    `RMP_ASSERT_NEXT(a_full_status, i_clk, i_rst_n, w_accept && !w_pop && w_full, r_s1_valid && r_s1_status == ST_FULL)

endmodule

[hw/rtl/rmp_cell.sv]
module rmp_cell
    import rmp_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 7
) (
    input  logic                      i_clk,
    input  t_cell_cmd                 i_cmd,
    input  logic [CW-1:0]             i_count,
    input  logic [CW-1:0]             i_pos,
    input  logic                      i_prev_b,
    input  logic signed [VALUE_W-1:0] i_prev_val,
    input  logic signed [VALUE_W-1:0] i_next_val,
    output logic                      o_b,
    output logic signed [VALUE_W-1:0] o_val,
    output logic        [VALUE_W-1:0] o_med
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic signed [VALUE_W-1:0] r_val;
    logic signed [VALUE_W-1:0] n_val;
    logic                      w_occ;

    assign w_occ = MY_IDX < i_count;
    assign o_b   = !w_occ || (r_val > i_cmd.value);
    assign o_val = r_val;
    assign o_med = (i_pos == MY_IDX) ? r_val : '0;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins_en && o_b) begin
            n_val = i_prev_b ? i_prev_val : i_cmd.value;
        end else if (i_cmd.pop_en && (MY_IDX >= i_pos)) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

[verif/running_median_pop_checker.sv]
`timescale 1ns / 100ps

module running_median_pop_checker
    import rmp_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [VALUE_W-1:0]  i_s_tdata,   // [31:0] value
    input  logic                i_s_tuser,   // [0] mode
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [VALUE_W-1:0]  i_m_tdata,   // [31:0] median
    input  logic [STATUS_W-1:0] i_m_tuser,   // [1:0] status
    output int                  o_errors,
    output int                  o_pending,
    output int                  o_in_beats,
    output int                  o_medians,
    output int                  o_empties,
    output int                  o_drops
);

    typedef struct {
        logic [VALUE_W-1:0] median;
        t_status            status;
    } t_outcome;

    logic signed [VALUE_W-1:0] sorted_store [CAPACITY];
    int                        store_count = 0;
    t_outcome                  outcome_q [$];
    int                        errors      = 0;
    int                        in_beats    = 0;
    int                        medians     = 0;
    int                        empties     = 0;
    int                        drops       = 0;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        if (errors < 50) begin
            $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
        end
        errors++;
    endtask

    task automatic queue_outcome(input t_outcome res);
        outcome_q.insert(outcome_q.size(), res);
    endtask

    task automatic predict_item(input t_mode mode, input logic signed [VALUE_W-1:0] value);
        t_outcome res;
        int       pos;
        res.median = '0;
        if (mode == MODE_INSERT) begin
            if (store_count >= CAPACITY) begin
                res.status = ST_FULL;
                queue_outcome(res);
            end else begin
                pos = 0;
                while (pos < store_count && sorted_store[pos] <= value) pos++;
                for (int k = store_count; k > pos; k--) sorted_store[k] = sorted_store[k-1];
                sorted_store[pos] = value;
                store_count++;
            end
        end else if (store_count == 0) begin
            res.status = ST_EMPTY;
            queue_outcome(res);
        end else begin
            pos        = (store_count - 1) / 2;
            res.median = sorted_store[pos];
            res.status = ST_OK;
            for (int k = pos; k + 1 < store_count; k++) sorted_store[k] = sorted_store[k+1];
            store_count--;
            queue_outcome(res);
        end
    endtask

    task automatic compare_beat();
        t_outcome want;
        if (outcome_q.size() == 0) begin
            report_mismatch("beat with nothing expected", i_m_tdata, '0);
        end else begin
            want = outcome_q.pop_front();
            if (i_m_tdata !== want.median) begin
                report_mismatch("median", i_m_tdata, want.median);
            end
            if (i_m_tuser !== want.status) begin
                report_mismatch("status", VALUE_W'(i_m_tuser), VALUE_W'(want.status));
            end
            case (want.status)
                ST_OK:    medians++;
                ST_EMPTY: empties++;
                default:  drops++;
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            store_count = 0;
            outcome_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) compare_beat();
            if (i_s_tvalid && i_s_tready) begin
                in_beats++;
                predict_item(t_mode'(i_s_tuser), i_s_tdata);
            end
        end
        o_errors   <= errors;
        o_pending  <= outcome_q.size();
        o_in_beats <= in_beats;
        o_medians  <= medians;
        o_empties  <= empties;
        o_drops    <= drops;
    end

endmodule

[verif/tb_running_median_pop.sv]
`timescale 1ns / 100ps

module tb_running_median_pop;
    import rmp_pkg::*;

    localparam int CAPACITY = DEFAULT_CAPACITY;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [VALUE_W-1:0]  s_tdata;    // [31:0] value
    logic                s_tuser;    // [0] mode
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [VALUE_W-1:0]  m_tdata;    // [31:0] median
    logic [STATUS_W-1:0] m_tuser;    // [1:0] status
    logic                quiet;

    int errors;
    int pending;
    int in_beats;
    int medians;
    int empties;
    int drops;

    running_median_pop #(
        .CAPACITY(CAPACITY)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    running_median_pop_checker #(
        .CAPACITY(CAPACITY)
    ) median_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_in_beats (in_beats),
        .o_medians  (medians),
        .o_empties  (empties),
        .o_drops    (drops)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 28);
    end

    initial begin
        #1_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000 + $urandom_range(0, 3);
            1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
            2, 3, 4: return $urandom_range(0, 15) - 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_item(input t_mode mode, input logic [VALUE_W-1:0] value);
        if (!quiet && $urandom_range(0, 99) < 28) begin
            s_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(0, 99) < 28);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= mode;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic run_phase(input int items, input int insert_pct);
        for (int i = 0; i < items; i++) begin
            if ($urandom_range(0, 99) < insert_pct) begin
                send_item(MODE_INSERT, pick_value());
            end else begin
                send_item(MODE_POP, $urandom());
            end
        end
    endtask

    initial begin
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_INSERT;
        quiet    <= 1'b0;
        rst_n    <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(MODE_POP, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h8000_0000);
        send_item(MODE_INSERT, 32'h7FFF_FFFF);
        send_item(MODE_INSERT, 32'h0000_0000);
        send_item(MODE_INSERT, 32'hFFFF_FFFF);
        send_item(MODE_INSERT, 32'h5555_5555);
        send_item(MODE_INSERT, 32'hAAAA_AAAA);
        send_item(MODE_INSERT, 32'h0000_0000);
        repeat (8) send_item(MODE_POP, 32'h0000_0000);
        repeat (3) send_item(MODE_INSERT, 32'h0000_0007);
        send_item(MODE_INSERT, 32'hFFFF_FFF9);
        repeat (4) send_item(MODE_POP, 32'h5A5A_5A5A);

        for (int r = 0; r < 2; r++) begin
            run_phase(100, 90);
            quiet <= (r == 0);
            run_phase(60, 50);
            quiet <= 1'b0;
            run_phase(100, 15);
        end

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Sent %0d input beats through fill, overflow, drain and mixed phases.",
                 in_beats);
        $display("Checked %0d medians, %0d pops on empty, %0d dropped inserts.",
                 medians, empties, drops);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
